// File: hdl/ugsi_pkg.sv
// Package for the uniform grid spatial index.
// Request/result transaction types, the queued command type and shared constants.
// Used by every module under hdl except ugsi_ram.
`default_nettype none

package ugsi_pkg;

    localparam int GRID_CELLS_DEF  = 16;
    localparam int CELL_WIDTH_DEF  = 64;
    localparam int CELL_HEIGHT_DEF = 64;
    localparam int CELL_SLOTS_DEF  = 16;
    localparam int MAX_FOUND_DEF   = 32;
    localparam int ENTITY_IDS_DEF  = 256;

    // Cell coordinates travel at the widest grid size the block supports.
    localparam int COORD_W = 8;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_OVER = 2'd2;

    typedef struct packed {
        req_t               req_type;
        logic [7:0]         entity_id;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [11:0]        size_w;
        logic [11:0]        size_h;
        logic               ignore_valid;
        logic [7:0]         ignore_id;
    } in_t;

    typedef struct packed {
        logic [7:0] out_entity;
        logic       has_entity;
        logic       last;
        logic [1:0] status;
    } out_t;

    typedef struct packed {
        req_t               req;
        logic [7:0]         id;
        logic               ign_valid;
        logic [7:0]         ign;
        logic [COORD_W-1:0] x_lo;
        logic [COORD_W-1:0] x_hi;
        logic [COORD_W-1:0] y_lo;
        logic [COORD_W-1:0] y_hi;
        logic               span_empty;
    } cmd_t;

endpackage

`default_nettype wire

// File: hdl/ugsi_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none

module ugsi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hdl/ugsi_fifo.sv
// Two-entry command queue between the front end and the execution engine.
// Depends on ugsi_pkg for cmd_t.
`default_nettype none

module ugsi_fifo
    import ugsi_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      push_cmd,
    output logic      full,
    input  wire logic pop,
    output cmd_t      head,
    output logic      empty
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// File: hdl/ugsi_front.sv
// Front end: accepts request transactions, maps boxes to clipped cell spans with a
// shared reciprocal-multiply divider and pushes commands into the queue. Depends on ugsi_pkg.
`default_nettype none

module ugsi_front
    import ugsi_pkg::*;
#(
    parameter int GRID_CELLS  = GRID_CELLS_DEF,
    parameter int CELL_WIDTH  = CELL_WIDTH_DEF,
    parameter int CELL_HEIGHT = CELL_HEIGHT_DEF,
    parameter int ENTITY_IDS  = ENTITY_IDS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  in_t       req,
    output logic      push,
    output cmd_t      push_cmd,
    input  wire logic full
);

    localparam bit          ID_MOD = (ENTITY_IDS < 256);
    localparam logic [7:0]  DEN_ID = 8'(ENTITY_IDS);
    localparam logic signed [17:0] GRID_MAX = 18'(GRID_CELLS - 1);

    // Magnitudes stay below 2^17; a shift of 17 + clog2(d) with a rounded-up
    // reciprocal gives the exact truncated quotient.
    localparam int SHX_I  = 17 + $clog2(CELL_WIDTH);
    localparam int SHY_I  = 17 + $clog2(CELL_HEIGHT);
    localparam int SHID_I = 17 + $clog2(ENTITY_IDS);
    localparam logic [5:0]  SH_X   = 6'(SHX_I);
    localparam logic [5:0]  SH_Y   = 6'(SHY_I);
    localparam logic [5:0]  SH_ID  = 6'(SHID_I);
    localparam logic [18:0] RCP_X  = 19'(((64'd1 << SHX_I) + 64'(CELL_WIDTH) - 64'd1)
                                        / 64'(CELL_WIDTH));
    localparam logic [18:0] RCP_Y  = 19'(((64'd1 << SHY_I) + 64'(CELL_HEIGHT) - 64'd1)
                                        / 64'(CELL_HEIGHT));
    localparam logic [18:0] RCP_ID = 19'(((64'd1 << SHID_I) + 64'(ENTITY_IDS) - 64'd1)
                                        / 64'(ENTITY_IDS));

    localparam logic [2:0] OP_XLO = 3'd0;
    localparam logic [2:0] OP_XHI = 3'd1;
    localparam logic [2:0] OP_YLO = 3'd2;
    localparam logic [2:0] OP_YHI = 3'd3;
    localparam logic [2:0] OP_ID  = 3'd4;
    localparam logic [2:0] OP_IGN = 3'd5;
    localparam logic [2:0] OP_END = ID_MOD ? OP_IGN : OP_YHI;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_LOAD = 4'b0010,
        F_DIV  = 4'b0100,
        F_PUSH = 4'b1000
    } fstate_t;

    fstate_t state_reg, state_next;
    logic [2:0] op_reg, op_next;
    in_t  req_reg;
    logic [16:0] mag_reg;
    logic        neg_reg;
    logic signed [17:0] xlo_reg, xhi_reg, ylo_reg, yhi_reg;
    logic [7:0] id_reg, ign_reg;

    logic signed [17:0] px, py, wd, ht, hw, hh, num;
    logic [16:0] mag, quo;
    logic [18:0] rcp;
    logic [5:0]  sh;
    logic [35:0] prod;
    logic [7:0]  rem_id;
    logic        is_query;
    logic signed [17:0] qres;
    logic signed [17:0] xlo_c, xhi_c, ylo_c, yhi_c;

    assign req_stall = (state_reg != F_IDLE);
    assign is_query  = (req_reg.req_type == REQ_QUERY);

    always_comb
    begin
        px = {{2{req_reg.pos_x[15]}}, req_reg.pos_x};
        py = {{2{req_reg.pos_y[15]}}, req_reg.pos_y};
        wd = {6'd0, req_reg.size_w};
        ht = {6'd0, req_reg.size_h};
        hw = {7'd0, req_reg.size_w[11:1]};
        hh = {7'd0, req_reg.size_h[11:1]};
        unique case (op_reg)
            OP_XLO:  num = is_query ? px : px - hw;
            OP_XHI:  num = is_query ? px + wd : px + hw;
            OP_YLO:  num = is_query ? py : py - hh;
            OP_YHI:  num = is_query ? py + ht : py + hh;
            OP_ID:   num = {10'd0, req_reg.entity_id};
            OP_IGN:  num = {10'd0, req_reg.ignore_id};
            default: num = '0;
        endcase
        mag = num[17] ? 17'(-num) : num[16:0];

        if (op_reg == OP_XLO || op_reg == OP_XHI)
        begin
            rcp = RCP_X;
            sh  = SH_X;
        end
        else if (op_reg == OP_YLO || op_reg == OP_YHI)
        begin
            rcp = RCP_Y;
            sh  = SH_Y;
        end
        else
        begin
            rcp = RCP_ID;
            sh  = SH_ID;
        end

        // Truncated quotient of the held magnitude, sign restored afterwards.
        prod   = {19'd0, mag_reg} * {17'd0, rcp};
        quo    = 17'(prod >> sh);
        qres   = neg_reg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        rem_id = 8'(mag_reg[7:0] - 8'(quo[7:0] * DEN_ID));

        // Clamp spans to the grid.
        xlo_c = (xlo_reg < 0) ? 18'sd0 : xlo_reg;
        xhi_c = (xhi_reg > GRID_MAX) ? GRID_MAX : xhi_reg;
        ylo_c = (ylo_reg < 0) ? 18'sd0 : ylo_reg;
        yhi_c = (yhi_reg > GRID_MAX) ? GRID_MAX : yhi_reg;

        push_cmd.req        = req_reg.req_type;
        push_cmd.id         = ID_MOD ? id_reg : req_reg.entity_id;
        push_cmd.ign_valid  = req_reg.ignore_valid;
        push_cmd.ign        = ID_MOD ? ign_reg : req_reg.ignore_id;
        push_cmd.x_lo       = xlo_c[COORD_W-1:0];
        push_cmd.x_hi       = xhi_c[COORD_W-1:0];
        push_cmd.y_lo       = ylo_c[COORD_W-1:0];
        push_cmd.y_hi       = yhi_c[COORD_W-1:0];
        push_cmd.span_empty = (xhi_c < xlo_c) || (yhi_c < ylo_c);
        push = (state_reg == F_PUSH);
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (req_valid)
                begin
                    op_next = OP_XLO;
                    state_next = (req.req_type == REQ_CLEAR) ? F_PUSH : F_LOAD;
                end
            end
            F_LOAD:
            begin
                state_next = F_DIV;
            end
            F_DIV:
            begin
                if (op_reg == OP_END)
                begin
                    state_next = F_PUSH;
                end
                else
                begin
                    op_next    = op_reg + 3'd1;
                    state_next = F_LOAD;
                end
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            op_reg    <= OP_XLO;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && req_valid)
        begin
            req_reg <= req;
            // A clear carries no span; mark it empty.
            xlo_reg <= 18'sd1;
            xhi_reg <= 18'sd0;
            ylo_reg <= 18'sd1;
            yhi_reg <= 18'sd0;
        end
        if (state_reg == F_LOAD)
        begin
            mag_reg <= mag;
            neg_reg <= num[17];
        end
        if (state_reg == F_DIV)
        begin
            unique case (op_reg)
                OP_XLO:  xlo_reg <= qres;
                OP_XHI:  xhi_reg <= qres;
                OP_YLO:  ylo_reg <= qres;
                OP_YHI:  yhi_reg <= qres;
                OP_ID:   id_reg  <= rem_id;
                OP_IGN:  ign_reg <= rem_id;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hdl/ugsi_back.sv
// Execution engine: walks the cell span of each queued command over the bucket,
// fill and candidate memories and drives the result register. Depends on ugsi_pkg.
`default_nettype none

module ugsi_back
    import ugsi_pkg::*;
#(
    parameter int GRID_CELLS = GRID_CELLS_DEF,
    parameter int CELL_SLOTS = CELL_SLOTS_DEF,
    parameter int MAX_FOUND  = MAX_FOUND_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic empty,
    input  cmd_t      head,
    output logic      pop,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output out_t      rsp
);

    localparam int NCELL = GRID_CELLS * GRID_CELLS;
    localparam int CW    = (NCELL > 1) ? $clog2(NCELL) : 1;
    localparam int GW    = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
    localparam int MDEP  = NCELL * CELL_SLOTS;
    localparam int MW    = (MDEP > 1) ? $clog2(MDEP) : 1;
    localparam int FW    = $clog2(CELL_SLOTS + 1);
    localparam int KW    = $clog2(MAX_FOUND + 1);
    localparam int FIW   = (MAX_FOUND > 1) ? $clog2(MAX_FOUND) : 1;

    typedef enum logic [10:0] {
        B_IDLE    = 11'b00000000001,
        B_FILL_RD = 11'b00000000010,
        B_FILL_EV = 11'b00000000100,
        B_MEM_RD  = 11'b00000001000,
        B_MEM_EV  = 11'b00000010000,
        B_FND_RD  = 11'b00000100000,
        B_FND_EV  = 11'b00001000000,
        B_NEXT    = 11'b00010000000,
        B_OUT_RD  = 11'b00100000000,
        B_OUT_EV  = 11'b01000000000,
        B_DONE    = 11'b10000000000
    } bstate_t;

    bstate_t state_reg, state_next;
    cmd_t    cmd_reg, cmd_next;
    logic [GW-1:0] x_reg, x_next, y_reg, y_next;
    logic [FW-1:0] fill_reg, fill_next, idx_reg, idx_next, keep_reg, keep_next;
    logic [7:0]    ent_reg, ent_next;
    logic [KW-1:0] scan_reg, scan_next, count_reg, count_next;
    logic [1:0]    status_reg, status_next;
    logic [NCELL-1:0] valid_reg, valid_next;
    logic  rsp_valid_reg, rsp_valid_next;
    out_t  rsp_reg, rsp_next;

    logic [CW-1:0] cell_addr;
    logic [FW-1:0] fill_cur, fill_rdata, fill_wdata, slot_w;
    logic          fill_we, mem_we, fnd_we;
    logic [MW-1:0] mem_raddr, mem_waddr;
    logic [7:0]    mem_rdata, mem_wdata, fnd_rdata;
    logic          can_load, emit;
    out_t          emit_data;

    assign cell_addr = CW'(CW'(x_reg) * CW'(GRID_CELLS) + CW'(y_reg));
    assign mem_raddr = MW'(MW'(cell_addr) * MW'(CELL_SLOTS) + MW'(idx_reg));
    assign mem_waddr = MW'(MW'(cell_addr) * MW'(CELL_SLOTS) + MW'(slot_w));
    assign fill_cur  = valid_reg[cell_addr] ? fill_rdata : '0;
    assign can_load  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    ugsi_ram #(.WIDTH(FW), .DEPTH(NCELL)) u_fill (
        .clk   (clk),
        .we    (fill_we),
        .waddr (cell_addr),
        .wdata (fill_wdata),
        .raddr (cell_addr),
        .rdata (fill_rdata)
    );

    ugsi_ram #(.WIDTH(8), .DEPTH(MDEP)) u_members (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ugsi_ram #(.WIDTH(8), .DEPTH(MAX_FOUND)) u_found (
        .clk   (clk),
        .we    (fnd_we),
        .waddr (FIW'(count_reg)),
        .wdata (ent_reg),
        .raddr (FIW'(scan_reg)),
        .rdata (fnd_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        fill_next   = fill_reg;
        idx_next    = idx_reg;
        keep_next   = keep_reg;
        ent_next    = ent_reg;
        scan_next   = scan_reg;
        count_next  = count_reg;
        status_next = status_reg;
        valid_next  = valid_reg;
        pop         = 1'b0;
        fill_we     = 1'b0;
        fill_wdata  = keep_reg;
        mem_we      = 1'b0;
        mem_wdata   = cmd_reg.id;
        slot_w      = keep_reg;
        fnd_we      = 1'b0;
        emit        = 1'b0;
        emit_data   = '{out_entity: 8'd0, has_entity: 1'b0, last: 1'b1, status: status_reg};

        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop         = 1'b1;
                    cmd_next    = head;
                    x_next      = head.x_lo[GW-1:0];
                    y_next      = head.y_lo[GW-1:0];
                    count_next  = '0;
                    status_next = ST_OK;
                    if (head.req == REQ_CLEAR)
                    begin
                        valid_next = '0;
                        state_next = B_DONE;
                    end
                    else if (head.span_empty)
                    begin
                        state_next = B_DONE;
                    end
                    else
                    begin
                        state_next = B_FILL_RD;
                    end
                end
            end
            B_FILL_RD:
            begin
                state_next = B_FILL_EV;
            end
            B_FILL_EV:
            begin
                fill_next = fill_cur;
                idx_next  = '0;
                keep_next = '0;
                if (cmd_reg.req == REQ_ADD)
                begin
                    if (fill_cur < FW'(CELL_SLOTS))
                    begin
                        slot_w                = fill_cur;
                        mem_we                = 1'b1;
                        fill_we               = 1'b1;
                        fill_wdata            = fill_cur + FW'(1);
                        valid_next[cell_addr] = 1'b1;
                    end
                    else
                    begin
                        status_next = ST_FULL;
                    end
                    state_next = B_NEXT;
                end
                else
                begin
                    state_next = B_MEM_RD;
                end
            end
            B_MEM_RD:
            begin
                if (idx_reg == fill_reg)
                begin
                    if (cmd_reg.req == REQ_REMOVE)
                    begin
                        fill_we               = 1'b1;
                        valid_next[cell_addr] = 1'b1;
                    end
                    state_next = B_NEXT;
                end
                else
                begin
                    state_next = B_MEM_EV;
                end
            end
            B_MEM_EV:
            begin
                idx_next = idx_reg + FW'(1);
                if (cmd_reg.req == REQ_REMOVE)
                begin
                    // Compact survivors toward the front of the bucket.
                    if (mem_rdata != cmd_reg.id)
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = mem_rdata;
                        keep_next = keep_reg + FW'(1);
                    end
                    state_next = B_MEM_RD;
                end
                else if (cmd_reg.ign_valid && mem_rdata == cmd_reg.ign)
                begin
                    state_next = B_MEM_RD;
                end
                else
                begin
                    ent_next   = mem_rdata;
                    scan_next  = '0;
                    state_next = B_FND_RD;
                end
            end
            B_FND_RD:
            begin
                if (scan_reg == count_reg)
                begin
                    if (count_reg < KW'(MAX_FOUND))
                    begin
                        fnd_we     = 1'b1;
                        count_next = count_reg + KW'(1);
                    end
                    else
                    begin
                        status_next = ST_OVER;
                    end
                    state_next = B_MEM_RD;
                end
                else
                begin
                    state_next = B_FND_EV;
                end
            end
            B_FND_EV:
            begin
                if (fnd_rdata == ent_reg)
                begin
                    state_next = B_MEM_RD;
                end
                else
                begin
                    scan_next  = scan_reg + KW'(1);
                    state_next = B_FND_RD;
                end
            end
            B_NEXT:
            begin
                if (y_reg == cmd_reg.y_hi[GW-1:0])
                begin
                    y_next = cmd_reg.y_lo[GW-1:0];
                    if (x_reg == cmd_reg.x_hi[GW-1:0])
                    begin
                        scan_next  = '0;
                        state_next = (cmd_reg.req == REQ_QUERY) ? B_OUT_RD : B_DONE;
                    end
                    else
                    begin
                        x_next     = x_reg + GW'(1);
                        state_next = B_FILL_RD;
                    end
                end
                else
                begin
                    y_next     = y_reg + GW'(1);
                    state_next = B_FILL_RD;
                end
            end
            B_OUT_RD:
            begin
                state_next = (count_reg == '0) ? B_DONE : B_OUT_EV;
            end
            B_OUT_EV:
            begin
                if (can_load)
                begin
                    emit      = 1'b1;
                    emit_data = '{out_entity: fnd_rdata, has_entity: 1'b1,
                                  last: (KW'(scan_reg + KW'(1)) == count_reg),
                                  status: status_reg};
                    scan_next = scan_reg + KW'(1);
                    state_next = (KW'(scan_reg + KW'(1)) == count_reg) ? B_IDLE : B_OUT_RD;
                end
            end
            B_DONE:
            begin
                if (can_load)
                begin
                    emit       = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase

        rsp_next       = emit ? emit_data : rsp_reg;
        rsp_valid_next = emit ? 1'b1 : (rsp_stall ? rsp_valid_reg : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            valid_reg     <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        fill_reg   <= fill_next;
        idx_reg    <= idx_next;
        keep_reg   <= keep_next;
        ent_reg    <= ent_next;
        scan_reg   <= scan_next;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

endmodule

`default_nettype wire

// File: hdl/uniform_grid_spatial_index.sv
// Top level of the uniform grid spatial index.
// Depends on ugsi_pkg, ugsi_front, ugsi_fifo, ugsi_back and ugsi_ram.
//
// A GRID_CELLS x GRID_CELLS grid of buckets, each holding up to CELL_SLOTS entity
// ids in insertion order. Every request transaction (add, remove, query, clear)
// returns one or more result transactions; the final one has last set. A request
// is first mapped to a clipped cell span by a shared reciprocal-multiply divider:
// four divisions (six when ENTITY_IDS is below 256), each a load step and a divide
// step, while a clear skips the divider. The front end stalls its input until the
// command is pushed, so it takes no new request while one is in progress. A two-entry
// queue then hands the command to the execution engine, which takes the command and
// visits the span one cell at a time: an add writes its id into the next free slot,
// a remove reads each bucket entry and compacts the survivors, a query reads each
// bucket entry and, for each entry not ignored, compares it with the candidates found
// so far and stores it when the id is new. A query gives one result per stored id (a
// single one when none); adds, removes and clears end with one result. Front end and
// engine overlap, so the sustained rate is set by the slower of the two, usually the
// engine on any request that touches filled cells. Adding to a full cell sets status
// 1; a query finding more than MAX_FOUND ids sets status 2 on all its results.
`default_nettype none

module uniform_grid_spatial_index
    import ugsi_pkg::*;
#(
    parameter int GRID_CELLS  = GRID_CELLS_DEF,
    parameter int CELL_WIDTH  = CELL_WIDTH_DEF,
    parameter int CELL_HEIGHT = CELL_HEIGHT_DEF,
    parameter int CELL_SLOTS  = CELL_SLOTS_DEF,
    parameter int MAX_FOUND   = MAX_FOUND_DEF,
    parameter int ENTITY_IDS  = ENTITY_IDS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  in_t       req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output out_t      rsp
);

    // Command path from front end to engine.
    logic push, full, pop, empty;
    cmd_t push_cmd, head;

    ugsi_front #(
        .GRID_CELLS  (GRID_CELLS),
        .CELL_WIDTH  (CELL_WIDTH),
        .CELL_HEIGHT (CELL_HEIGHT),
        .ENTITY_IDS  (ENTITY_IDS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (full)
    );

    ugsi_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    ugsi_back #(
        .GRID_CELLS (GRID_CELLS),
        .CELL_SLOTS (CELL_SLOTS),
        .MAX_FOUND  (MAX_FOUND)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .head      (head),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// File: verif/tb_uniform_grid_spatial_index.sv
// Testbench for the uniform grid spatial index: random and directed requests
// checked against a behavioral grid model held in a small scoreboard class.
// Depends on ugsi_pkg and uniform_grid_spatial_index.
`timescale 1ns / 1ps

module tb_uniform_grid_spatial_index;
    import ugsi_pkg::*;

    localparam int GRID  = 16;
    localparam int CW    = 64;
    localparam int CH    = 64;
    localparam int SLOTS = 16;
    localparam int MAXF  = 32;

    // Grid model and pending result store.
    class grid_scoreboard;
        bit [7:0] members[GRID*GRID][SLOTS];
        int       fill[GRID*GRID];
        out_t     pending[$];
        int       mismatches;
        int       results_seen;

        function void clear_cells();
            foreach (fill[i]) fill[i] = 0;
        endfunction

        // Clamp a cell span to the grid; returns 0 when empty.
        function bit clamp(int lo, int hi, output int a, output int b);
            a = (lo < 0) ? 0 : lo;
            b = (hi > GRID - 1) ? GRID - 1 : hi;
            return a <= b;
        endfunction

        // Apply one accepted request and queue its expected results.
        function void note_request(in_t r);
            int px, py, w, h, x1, x2, y1, y2, c, n, nf;
            bit [7:0] found[MAXF];
            bit [1:0] st;
            bit seen;
            out_t o;
            px = r.pos_x;
            py = r.pos_y;
            w = r.size_w;
            h = r.size_h;
            st = ST_OK;
            nf = 0;
            if (r.req_type == REQ_CLEAR)
            begin
                clear_cells();
            end
            else if (r.req_type == REQ_QUERY)
            begin
                if (clamp(px / CW, (px + w) / CW, x1, x2) &&
                    clamp(py / CH, (py + h) / CH, y1, y2))
                begin
                    for (int x = x1; x <= x2; x++)
                        for (int y = y1; y <= y2; y++)
                        begin
                            c = x * GRID + y;
                            for (int i = 0; i < fill[c]; i++)
                            begin
                                if (r.ignore_valid && members[c][i] == r.ignore_id)
                                    continue;
                                seen = 0;
                                for (int j = 0; j < nf; j++)
                                    if (found[j] == members[c][i]) seen = 1;
                                if (seen) continue;
                                if (nf < MAXF)
                                begin
                                    found[nf] = members[c][i];
                                    nf++;
                                end
                                else
                                    st = ST_OVER;
                            end
                        end
                end
                for (int k = 0; k < nf; k++)
                begin
                    o = '{found[k], 1'b1, k == nf - 1, st};
                    pending.push_back(o);
                end
                if (nf != 0) return;
            end
            else if (clamp((px - w / 2) / CW, (px + w / 2) / CW, x1, x2) &&
                     clamp((py - h / 2) / CH, (py + h / 2) / CH, y1, y2))
            begin
                for (int x = x1; x <= x2; x++)
                    for (int y = y1; y <= y2; y++)
                    begin
                        c = x * GRID + y;
                        if (r.req_type == REQ_ADD)
                        begin
                            if (fill[c] < SLOTS)
                            begin
                                members[c][fill[c]] = r.entity_id;
                                fill[c]++;
                            end
                            else
                                st = ST_FULL;
                        end
                        else
                        begin
                            n = 0;
                            for (int i = 0; i < fill[c]; i++)
                                if (members[c][i] != r.entity_id)
                                begin
                                    members[c][n] = members[c][i];
                                    n++;
                                end
                            fill[c] = n;
                        end
                    end
            end
            o = '{8'd0, 1'b0, 1'b1, st};
            pending.push_back(o);
        endfunction

        function void check_result(out_t got);
            out_t want;
            results_seen++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p got %p", want, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    in_t  req;
    logic rsp_valid;
    logic rsp_stall;
    out_t rsp;

    grid_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    int  n_items;

    uniform_grid_spatial_index u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Receiver: drive stall at the falling edge, sample at the rising edge.
    always @(negedge clk)
        rsp_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(rsp);

    // Send one request transaction; hold it until accepted. Valid stays high on
    // return so a back-to-back request replaces it at the same falling edge.
    task automatic send_request(in_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_request(r);
        n_items++;
        @(negedge clk);
    endtask

    function automatic in_t make_req(bit [1:0] t, bit [7:0] id, int x, int y,
                                     int w, int h, bit iv, bit [7:0] ig);
        in_t r;
        r.req_type = req_t'(t);
        r.entity_id = id;
        r.pos_x = 16'(x);
        r.pos_y = 16'(y);
        r.size_w = 12'(w);
        r.size_h = 12'(h);
        r.ignore_valid = iv;
        r.ignore_id = ig;
        return r;
    endfunction

    // Mostly in-grid boxes with small sizes, ids from a small pool for hits.
    function automatic in_t random_req();
        in_t r;
        int  sel;
        r = '0;
        sel = $urandom_range(99);
        r.req_type = sel < 45 ? REQ_ADD : sel < 65 ? REQ_REMOVE :
                     sel < 97 ? REQ_QUERY : REQ_CLEAR;
        r.entity_id = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(40));
        if ($urandom_range(9) == 0)
        begin
            r.pos_x = 16'($urandom);
            r.pos_y = 16'($urandom);
            r.size_w = 12'($urandom);
            r.size_h = 12'($urandom);
        end
        else
        begin
            r.pos_x = 16'($signed($urandom_range(1100)) - 50);
            r.pos_y = 16'($signed($urandom_range(1100)) - 50);
            r.size_w = 12'($urandom_range(200));
            r.size_h = 12'($urandom_range(200));
        end
        r.ignore_valid = 1'($urandom);
        r.ignore_id = ($urandom_range(1) == 0) ? r.entity_id : 8'($urandom);
        return r;
    endfunction

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // Watchdog for a hung block.
    initial
    begin
        #100ms;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        sb = new();
        sb.clear_cells();
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_stall = 1'b0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        n_items = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, every request type, full cell, overflow.
        send_request(make_req(REQ_QUERY, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(REQ_ADD, 8'hff, -32768, -32768, 4095, 4095, 0, 0));
        send_request(make_req(REQ_ADD, 0, 32767, 32767, 4095, 4095, 1, 8'hff));
        send_request(make_req(REQ_ADD, 8'h55, 0, 0, 0, 0, 0, 0));
        send_request(make_req(REQ_QUERY, 0, -32768, -32768, 4095, 4095, 1, 8'hff));
        send_request(make_req(REQ_QUERY, 0, 32767, 32767, 4095, 4095, 0, 0));
        for (int i = 0; i < 17; i++)
            send_request(make_req(REQ_ADD, 8'(i * 15), 10, 10, 150, 0, 0, 0));
        send_request(make_req(REQ_QUERY, 0, 0, 0, 200, 200, 1, 8'd30));
        send_request(make_req(REQ_REMOVE, 8'd15, 10, 10, 150, 0, 0, 0));
        send_request(make_req(REQ_QUERY, 0, 0, 0, 100, 0, 0, 0));
        send_request(make_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        wait_drained();

        // Candidate overflow: 40 distinct ids over four cells in a row, one query over them.
        for (int i = 0; i < 40; i++)
            send_request(make_req(REQ_ADD, 8'(100 + i), 64 * (i % 4), 64, 0, 0, 0, 0));
        send_request(make_req(REQ_QUERY, 0, 0, 0, 255, 100, 0, 0));
        send_request(make_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0));

        // Random phases with different idling mixes.
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = ph == 1 ? 65 : ph == 3 ? 7 : 0;
            recv_stall_pct = ph == 2 ? 65 : ph == 3 ? 7 : 0;
            for (int i = 0; i < 68; i++)
                send_request(random_req());
        end

        // Long receiver hold-off so the block backs up and stalls its input.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 30; i++)
                send_request(random_req());
        join

        wait_drained();
        $display("Covered %0d request transactions and %0d result transactions,",
                 n_items, sb.results_seen);
        $display("%0d mismatches, across idle, stall and hold-off phases.", sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
